@@ rtl/core/integer_stack_engine_assert.svh @@
// ---------------------------------------------------------------------------
// integer_stack_engine_assert.svh
// Assertion macros shared by the stack engine checker.
// ---------------------------------------------------------------------------
`ifndef INTEGER_STACK_ENGINE_ASSERT_SVH
`define INTEGER_STACK_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISE_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stack engine check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ISE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stack engine check failed");

`endif

@@ rtl/core/ise_pkg.sv @@
// ---------------------------------------------------------------------------
// ise_pkg
// Types, codes and sizes shared by the integer stack engine files.
// ---------------------------------------------------------------------------
package ise_pkg;

    // Number of stack entries, from 2 to 64.
    localparam int DEPTH  = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // Command codes.
    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_DUMP = 3'd1;
    localparam logic [2:0] OP_PEEK = 3'd2;
    localparam logic [2:0] OP_POP  = 3'd3;
    localparam logic [2:0] OP_SWAP = 3'd4;

    // Status codes.
    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_PEEK_EMPTY = 3'd1;
    localparam logic [2:0] STATUS_POP_EMPTY  = 3'd2;
    localparam logic [2:0] STATUS_SWAP_SHORT = 3'd3;
    localparam logic [2:0] STATUS_PUSH_FULL  = 3'd4;
    localparam logic [2:0] STATUS_HALTED     = 3'd5;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] push_value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               has_value;
        logic [2:0]         status;
        logic               last;
    } result_t;

    // Access request from the controller to the entry memory.
    typedef struct packed {
        logic               wr_en;
        addr_t              wr_addr;
        logic signed [31:0] wr_data;
        logic               rd_en;
        addr_t              rd_addr;
    } mem_req_t;

endpackage

@@ rtl/core/ise_mem.sv @@
// ---------------------------------------------------------------------------
// ise_mem
// Stack entry storage: one write port and one read port, registered read.
// ---------------------------------------------------------------------------
module ise_mem (
    input  logic                clk,
    input  ise_pkg::mem_req_t   req,
    output logic signed [31:0]  rd_data
);

    logic signed [31:0] mem [ise_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

@@ rtl/core/integer_stack_engine.sv @@
// ---------------------------------------------------------------------------
// integer_stack_engine
// LIFO stack of signed 32-bit words with push, pop, swap, peek and dump.
// ---------------------------------------------------------------------------
// Push, pop, unknown commands, errors and halted commands: result in the cycle
// after the accept edge, busy stays low, so a new command can follow at once.
// Peek: busy in ST_PEEK; the word passes the memory read and result registers.
// Swap: busy in ST_SWAP_RD/WR/FIN (two reads, two writes through one memory).
// Dump: the first word passes the read and result registers, then one per cycle.
// Reset clears the fill count and the halt flag; entries are not cleared.
// ---------------------------------------------------------------------------
module integer_stack_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ise_pkg::cmd_t     cmd,
    output logic              result_valid,
    output ise_pkg::result_t  result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEEK,
        ST_SWAP_RD,
        ST_SWAP_WR,
        ST_SWAP_FIN,
        ST_DUMP
    } state_t;

    state_t             state_reg, state_next;
    ise_pkg::cnt_t      fill_reg, fill_next;
    logic               halted_reg, halted_next;
    ise_pkg::addr_t     idx_reg, idx_next;
    logic signed [31:0] swap_a_reg, swap_a_next;
    ise_pkg::result_t   result_reg, result_next;
    logic               valid_reg, valid_next;

    ise_pkg::mem_req_t  mem_req;
    logic signed [31:0] rd_data;

    // Addresses of the top entry and the one beneath it. Only used when the
    // fill count is large enough for them to be meaningful.
    ise_pkg::cnt_t      fill_m1;
    ise_pkg::cnt_t      fill_m2;
    ise_pkg::addr_t     top_addr;
    ise_pkg::addr_t     second_addr;
    logic               empty;
    logic               full;

    assign fill_m1     = fill_reg - ise_pkg::CNT_W'(1);
    assign fill_m2     = fill_reg - ise_pkg::CNT_W'(2);
    assign top_addr    = fill_m1[ise_pkg::ADDR_W-1:0];
    assign second_addr = fill_m2[ise_pkg::ADDR_W-1:0];
    assign empty       = (fill_reg == '0);
    assign full        = (fill_reg == ise_pkg::CNT_W'(ise_pkg::DEPTH));

    ise_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        halted_next = halted_reg;
        idx_next    = idx_reg;
        swap_a_next = swap_a_reg;
        valid_next  = 1'b0;

        // Default result: a single status-only word that closes the command.
        result_next           = '0;
        result_next.status    = ise_pkg::STATUS_OK;
        result_next.last      = 1'b1;

        mem_req         = '0;
        mem_req.wr_addr = top_addr;
        mem_req.rd_addr = top_addr;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    valid_next = 1'b1;
                    if (halted_reg)
                    begin
                        // Sticky halt: answer and change nothing.
                        result_next.status = ise_pkg::STATUS_HALTED;
                    end
                    else
                    begin
                        unique case (cmd.op)
                            ise_pkg::OP_PUSH:
                            begin
                                if (full)
                                begin
                                    result_next.status = ise_pkg::STATUS_PUSH_FULL;
                                    halted_next        = 1'b1;
                                end
                                else
                                begin
                                    mem_req.wr_en   = 1'b1;
                                    mem_req.wr_addr = fill_reg[ise_pkg::ADDR_W-1:0];
                                    mem_req.wr_data = cmd.push_value;
                                    fill_next       = fill_reg + ise_pkg::CNT_W'(1);
                                end
                            end
                            ise_pkg::OP_DUMP:
                            begin
                                // An empty dump is a single status word.
                                if (!empty)
                                begin
                                    valid_next    = 1'b0;
                                    mem_req.rd_en = 1'b1;
                                    idx_next      = top_addr;
                                    state_next    = ST_DUMP;
                                end
                            end
                            ise_pkg::OP_PEEK:
                            begin
                                if (empty)
                                begin
                                    result_next.status = ise_pkg::STATUS_PEEK_EMPTY;
                                    halted_next        = 1'b1;
                                end
                                else
                                begin
                                    valid_next    = 1'b0;
                                    mem_req.rd_en = 1'b1;
                                    state_next    = ST_PEEK;
                                end
                            end
                            ise_pkg::OP_POP:
                            begin
                                if (empty)
                                begin
                                    result_next.status = ise_pkg::STATUS_POP_EMPTY;
                                    halted_next        = 1'b1;
                                end
                                else
                                begin
                                    fill_next = fill_m1;
                                end
                            end
                            ise_pkg::OP_SWAP:
                            begin
                                if (fill_reg < ise_pkg::CNT_W'(2))
                                begin
                                    result_next.status = ise_pkg::STATUS_SWAP_SHORT;
                                    halted_next        = 1'b1;
                                end
                                else
                                begin
                                    valid_next    = 1'b0;
                                    mem_req.rd_en = 1'b1;
                                    state_next    = ST_SWAP_RD;
                                end
                            end
                            default:
                            begin
                                // Unrecognized commands are acknowledged and ignored.
                            end
                        endcase
                    end
                end
            end

            ST_PEEK:
            begin
                valid_next            = 1'b1;
                result_next.value     = rd_data;
                result_next.has_value = 1'b1;
                state_next            = ST_IDLE;
            end

            ST_SWAP_RD:
            begin
                // The top word is on the read port; fetch the one beneath it.
                swap_a_next     = rd_data;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = second_addr;
                state_next      = ST_SWAP_WR;
            end

            ST_SWAP_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = top_addr;
                mem_req.wr_data = rd_data;
                state_next      = ST_SWAP_FIN;
            end

            ST_SWAP_FIN:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = second_addr;
                mem_req.wr_data = swap_a_reg;
                valid_next      = 1'b1;
                state_next      = ST_IDLE;
            end

            ST_DUMP:
            begin
                // The word at idx_reg is on the read port; fetch the next one
                // down while this one goes out.
                valid_next            = 1'b1;
                result_next.value     = rd_data;
                result_next.has_value = 1'b1;
                result_next.last      = (idx_reg == '0);
                if (idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_reg - ise_pkg::ADDR_W'(1);
                    idx_next        = idx_reg - ise_pkg::ADDR_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            halted_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            halted_reg <= halted_next;
            valid_reg  <= valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        swap_a_reg <= swap_a_next;
        result_reg <= result_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

@@ rtl/core/integer_stack_engine_checker.sv @@
// ---------------------------------------------------------------------------
// integer_stack_engine_checker
// Port-level checks on the stack engine, bound to the top level.
// ---------------------------------------------------------------------------
`include "integer_stack_engine_assert.svh"

module integer_stack_engine_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              result_valid,
    input ise_pkg::result_t  result
);

    logic ends_busy;
    assign ends_busy = !busy && start;

    // A word that carries a stack entry always reports success.
    `ISE_ASSERT_IMPLIES(a_value_ok, clk, rst_n, result_valid && result.has_value, result.status == ise_pkg::STATUS_OK)

    // Words without an entry carry a zero value.
    `ISE_ASSERT_IMPLIES(a_value_zero, clk, rst_n, result_valid && !result.has_value, result.value == '0)

    // Leaving a multi-cycle command coincides with its closing word.
    `ISE_ASSERT_IMPLIES(a_busy_end, clk, rst_n, $fell(busy), result_valid && result.last)

    // More words are still to come only while the engine is busy.
    `ISE_ASSERT_IMPLIES(a_more_busy, clk, rst_n, result_valid && !result.last, busy || ends_busy == 1'b0 && busy)

endmodule

bind integer_stack_engine integer_stack_engine_checker u_checker (.*);

@@ test/stack_check_pkg.sv @@
// ---------------------------------------------------------------------------
// stack_check_pkg
// Scoreboard for the integer stack engine. It keeps its own copy of the
// stack, predicts the result words of every accepted command and compares
// each result word field by field with the oldest prediction.
// ---------------------------------------------------------------------------
package stack_check_pkg;

    import ise_pkg::*;

    class stack_scoreboard;

        logic signed [31:0] shadow_entries [DEPTH];
        int unsigned        depth;
        bit                 halted;
        result_t            pending_words [$];
        int unsigned        mismatches;
        int unsigned        words_checked;
        int unsigned        peak_depth;
        int unsigned        op_seen [8];

        function new();
            depth         = 0;
            halted        = 1'b0;
            mismatches    = 0;
            words_checked = 0;
            peak_depth    = 0;
            foreach (op_seen[i])
                op_seen[i] = 0;
        endfunction

        function void expect_single(logic signed [31:0] val, logic hv, logic [2:0] st);
            result_t w;
            w.value     = val;
            w.has_value = hv;
            w.status    = st;
            w.last      = 1'b1;
            pending_words.push_back(w);
        endfunction

        // An error answers once and freezes the stack for the rest of the run.
        function void raise_error(logic [2:0] st);
            halted = 1'b1;
            expect_single('0, 1'b0, st);
        endfunction

        // Applies one accepted command to the shadow stack and queues the
        // words that the engine must return for it.
        function void apply_command(cmd_t c);
            result_t            w;
            logic signed [31:0] held;
            int unsigned        k;
            op_seen[c.op]++;
            if (halted)
            begin
                expect_single('0, 1'b0, STATUS_HALTED);
                return;
            end
            case (c.op)
                OP_PUSH:
                    if (depth >= DEPTH)
                        raise_error(STATUS_PUSH_FULL);
                    else
                    begin
                        shadow_entries[depth] = c.push_value;
                        depth++;
                        if (depth > peak_depth)
                            peak_depth = depth;
                        expect_single('0, 1'b0, STATUS_OK);
                    end
                OP_DUMP:
                    if (depth == 0)
                        expect_single('0, 1'b0, STATUS_OK);
                    else
                        for (k = 0; k < depth; k++)
                        begin
                            w.value     = shadow_entries[depth - 1 - k];
                            w.has_value = 1'b1;
                            w.status    = STATUS_OK;
                            w.last      = (k + 1 == depth);
                            pending_words.push_back(w);
                        end
                OP_PEEK:
                    if (depth == 0)
                        raise_error(STATUS_PEEK_EMPTY);
                    else
                        expect_single(shadow_entries[depth - 1], 1'b1, STATUS_OK);
                OP_POP:
                    if (depth == 0)
                        raise_error(STATUS_POP_EMPTY);
                    else
                    begin
                        depth--;
                        expect_single('0, 1'b0, STATUS_OK);
                    end
                OP_SWAP:
                    if (depth < 2)
                        raise_error(STATUS_SWAP_SHORT);
                    else
                    begin
                        held                      = shadow_entries[depth - 1];
                        shadow_entries[depth - 1] = shadow_entries[depth - 2];
                        shadow_entries[depth - 2] = held;
                        expect_single('0, 1'b0, STATUS_OK);
                    end
                default:
                    expect_single('0, 1'b0, STATUS_OK);
            endcase
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 40)
                $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        task check_word(result_t got);
            result_t want;
            if (pending_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word value=%0d has_value=%0b status=%0d last=%0b",
                                          got.value, got.has_value, got.status, got.last));
                return;
            end
            want = pending_words.pop_front();
            words_checked++;
            if (got.value !== want.value)
                report_mismatch($sformatf("value %0d, predicted %0d", got.value, want.value));
            if (got.has_value !== want.has_value)
                report_mismatch($sformatf("has_value %0b, predicted %0b",
                                          got.has_value, want.has_value));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, predicted %0d", got.status, want.status));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0b, predicted %0b", got.last, want.last));
        endtask

    endclass

endpackage

@@ test/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Self-checking test of integer_stack_engine. A directed opening covers the
// value extremes, every command and the unknown codes; random command
// sequences then grow, shuffle, dump and drain the stack, reaching full
// depth at least once. The run closes with one randomly chosen error and a
// few commands that must answer halted.
// ---------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ise_pkg::*;
    import stack_check_pkg::*;

    // Cycles without any accepted command or result word before giving up.
    // The slowest legal stretch is a sender gap plus a swap, well under this.
    localparam int IDLE_LIMIT   = 2000;
    // Commands in the random part. The directed opening, the segment
    // overshoot and the closing fill or drain bring the run to about 260.
    localparam int RANDOM_ITEMS = 190;
    // Quiet cycles after the last predicted word; a stray word here fails.
    localparam int DRAIN_CYCLES = 16;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    result_valid;
    result_t result;

    stack_scoreboard sb;

    // Stack depth as the stimulus sees it. It is kept apart from the
    // scoreboard so that choosing the next command never races with the
    // scoreboard update at the same clock edge.
    int unsigned stim_depth;
    int unsigned cmd_count;
    int unsigned burst_left;
    int unsigned idle_cycles;
    bit          reached_full;
    string       closing_error;

    integer_stack_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Monitor: a command is taken at an edge where start is high and busy is
    // low, and a result word is taken at every edge where result_valid is
    // high. Both are sampled before the design updates at that edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.apply_command(cmd);
            if (result_valid)
                sb.check_word(result);
            if ((start && !busy) || result_valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog, checked on the falling edge so that it never races with the
    // counter update on the rising edge.
    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(negedge clk);
        $display("No progress for %0d cycles, giving up.", IDLE_LIMIT);
        $display("integer_stack_engine verification failed");
        $finish;
    end

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Picks a random command that cannot trip an error at the current depth.
    // A small share of unknown codes is mixed in as noise.
    function automatic logic [2:0] pick_op();
        int unsigned roll;
        logic [2:0]  op;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            op = OP_PUSH;
        else if (roll < 55)
            op = OP_POP;
        else if (roll < 70)
            op = OP_PEEK;
        else if (roll < 85)
            op = OP_SWAP;
        else if (roll < 93)
            op = OP_DUMP;
        else
            op = 3'($urandom_range(5, 7));
        if ((op == OP_POP || op == OP_PEEK) && stim_depth == 0)
            op = OP_PUSH;
        else if (op == OP_SWAP && stim_depth < 2)
            op = OP_PUSH;
        else if (op == OP_PUSH && stim_depth >= DEPTH)
            op = OP_POP;
        return op;
    endfunction

    // Presents one command word and returns at the edge that accepts it.
    // The sender works in bursts; between bursts start drops for a random
    // number of cycles, and sometimes bursts follow each other directly.
    task automatic send_word(logic [2:0] op, logic signed [31:0] val);
        cmd_t        w;
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 99) < 35) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                cmd   <= cmd_t'({$urandom, $urandom});
                repeat (gap - 1) @(negedge clk);
            end
        end
        w.op         = op;
        w.push_value = val;
        @(negedge clk);
        start <= 1'b1;
        cmd   <= w;
        do
            @(posedge clk);
        while (busy);
        burst_left--;
    endtask

    task automatic issue(logic [2:0] op, logic signed [31:0] val);
        send_word(op, val);
        if (op <= OP_SWAP)
            cmd_count++;
        if (op == OP_PUSH && stim_depth < DEPTH)
            stim_depth++;
        else if (op == OP_POP && stim_depth > 0)
            stim_depth--;
        if (stim_depth == DEPTH)
            reached_full = 1'b1;
    endtask

    task automatic drain_to(int unsigned target);
        while (stim_depth > target)
            issue(OP_POP, rand_word());
    endtask

    task automatic fill_to(int unsigned target);
        while (stim_depth < target)
            issue(OP_PUSH, rand_word());
    endtask

    initial
    begin : main
        int unsigned seg;
        int unsigned n;
        int unsigned target;
        int unsigned k;
        int unsigned goal;
        logic [2:0]  op;

        sb           = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        stim_depth   = 0;
        cmd_count    = 0;
        burst_left   = 0;
        idle_cycles  = 0;
        reached_full = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening: value extremes and alternating bit patterns,
        // then every command on a short stack, the unknown codes, a dump of
        // one entry and a dump of an empty stack.
        issue(OP_PUSH, 32'sh8000_0000);
        issue(OP_PUSH, 32'sh7fff_ffff);
        issue(OP_PUSH, 32'sh0);
        issue(OP_PUSH, -32'sd1);
        issue(OP_PUSH, 32'sd1);
        issue(OP_PUSH, 32'shaaaa_aaaa);
        issue(OP_PUSH, 32'sh5555_5555);
        issue(OP_PEEK, rand_word());
        issue(OP_SWAP, rand_word());
        issue(OP_PEEK, rand_word());
        issue(OP_DUMP, rand_word());
        issue(3'd5, rand_word());
        issue(3'd6, rand_word());
        issue(3'd7, rand_word());
        issue(OP_POP, rand_word());
        issue(OP_PEEK, rand_word());
        issue(OP_SWAP, rand_word());
        issue(OP_DUMP, rand_word());
        drain_to(1);
        issue(OP_DUMP, rand_word());
        issue(OP_POP, rand_word());
        issue(OP_DUMP, rand_word());

        // Random part. Sequences never trip an error, so the stack keeps
        // working; a full-depth fill is forced if chance has not reached it
        // by the halfway point.
        goal = cmd_count + RANDOM_ITEMS;
        while (cmd_count < goal || !reached_full)
        begin
            seg = $urandom_range(0, 9);
            if (!reached_full && cmd_count + RANDOM_ITEMS / 2 >= goal)
                seg = 9;
            if (seg <= 5)
            begin
                n = $urandom_range(8, 30);
                repeat (n)
                begin
                    op = pick_op();
                    issue(op, rand_word());
                end
            end
            else if (seg <= 7)
            begin
                target = $urandom_range(0, stim_depth);
                while (stim_depth > target)
                begin
                    issue(OP_POP, rand_word());
                    if (stim_depth > 0 && $urandom_range(0, 7) == 0)
                        issue(OP_PEEK, rand_word());
                end
                issue(OP_DUMP, rand_word());
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    target = DEPTH;
                else
                    target = $urandom_range(stim_depth, DEPTH);
                fill_to(target);
                issue(OP_DUMP, rand_word());
                if (stim_depth >= 2)
                    issue(OP_SWAP, rand_word());
                if (stim_depth > 0)
                    issue(OP_PEEK, rand_word());
                issue(OP_DUMP, rand_word());
            end
        end

        // Closing error. Only one can happen per run because the halt is
        // sticky and reset is never asserted again, so the seed picks which.
        case ($urandom_range(0, 3))
            0:
            begin
                drain_to(0);
                issue(OP_PEEK, rand_word());
                closing_error = "peek on an empty stack";
            end
            1:
            begin
                drain_to(0);
                issue(OP_POP, rand_word());
                closing_error = "pop on an empty stack";
            end
            2:
            begin
                drain_to($urandom_range(0, 1));
                issue(OP_SWAP, rand_word());
                closing_error = "swap with fewer than two entries";
            end
            default:
            begin
                fill_to(DEPTH);
                issue(OP_PUSH, rand_word());
                closing_error = "push onto a full stack";
            end
        endcase

        // Every command after the error must answer halted.
        for (k = 0; k < 6; k++)
        begin
            op = (k < 5) ? 3'(k) : 3'($urandom_range(5, 7));
            issue(op, rand_word());
        end

        @(negedge clk);
        start <= 1'b0;
        cmd   <= cmd_t'({$urandom, $urandom});

        while (sb.pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending_words.size() != 0)
            sb.report_mismatch($sformatf("%0d predicted words never arrived",
                                         sb.pending_words.size()));

        $display("Covered %0d pushes, %0d dumps, %0d peeks, %0d pops, %0d swaps, %0d unknown codes.",
                 sb.op_seen[OP_PUSH], sb.op_seen[OP_DUMP], sb.op_seen[OP_PEEK],
                 sb.op_seen[OP_POP], sb.op_seen[OP_SWAP],
                 sb.op_seen[5] + sb.op_seen[6] + sb.op_seen[7]);
        $display("Checked %0d result words, peak depth %0d, run closed by %s; %0d mismatches.",
                 sb.words_checked, sb.peak_depth, closing_error, sb.mismatches);
        if (sb.mismatches == 0)
            $display("integer_stack_engine verification clean");
        else
            $display("integer_stack_engine verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/ise_pkg.sv
rtl/core/ise_mem.sv
rtl/core/integer_stack_engine.sv
rtl/core/integer_stack_engine_checker.sv
test/stack_check_pkg.sv
test/testbench.sv
